// ===== hw/rtl/fta_pkg.sv =====
// Shared types and constants for the fault table aggregator.
package fta_pkg;

	localparam int MaxFaults = 32;
	localparam int IdxW      = $clog2(MaxFaults);
	localparam int CntW      = $clog2(MaxFaults + 1);
	localparam int TicksW    = 16;
	localparam int CfgAddrW  = 3;

	localparam logic [TicksW-1:0] HoldoffReset = 16'd50;

	// Byte address of the hold-off register.
	localparam logic [CfgAddrW-1:0] AddrHoldoff = 3'd0;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StFull    = 2'd1;
	localparam logic [1:0] StRefused = 2'd2;

	typedef enum logic [2:0] {
		OP_REGISTER  = 3'd0,
		OP_TRIGGER   = 3'd1,
		OP_CLEAR_ONE = 3'd2,
		OP_CLEAR_NP  = 3'd3,
		OP_GCLEAR    = 3'd4,
		OP_TICK      = 3'd5
	} fta_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_SCAN,
		ST_CLEAR,
		ST_TABLE,
		ST_DONE
	} fta_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd_idx;
		logic wr_rmw;
		logic walk_start;
		logic walk_step;
		logic walk_clear;
		logic do_register;
		logic do_tick;
		logic apply_table;
		logic gclear_commit;
		logic set_refused;
		logic emit;
	} fta_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		fta_op_t op;
		logic    idx_valid;
		logic    walk_done;
		logic    refuse;
	} fta_stat_t;

endpackage

// ===== hw/rtl/fault_table_aggregator_core.sv =====
// Top level of the fault table aggregator: register port, controller and datapath.
// Register, tick and unused commands, and a trigger or clear one on an unregistered index,
// go straight to the result; trigger and clear one read, modify and write their entry and
// then walk the table, clear non-permanent walks it once, and a global clear walks it once
// more to clear it when not refused. The table walk reads one entry per cycle.
// One command is in flight at a time; the next is taken only once the controller is idle. The result
// beat cannot be stalled. Reset clears the table count, signals, latches and hold-off.
module fault_table_aggregator_core import fta_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Command beat.
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [4:0]          fault_index,
	input  logic                is_permanent,
	input  logic                is_resettable,
	input  logic                pin_fault_level,
	input  logic                pin_faultn_level,
	// Result beat.
	output logic                done,
	output logic [1:0]          status,
	output logic [4:0]          assigned_index,
	output logic                fault_out,
	output logic                faultn_out,
	output logic                clearing
);

	logic [TicksW-1:0] hold_ticks_q;
	logic              cfg_wr;
	fta_cmd_t          cmd;
	fta_stat_t         stat;

	// The single register sits at byte address zero; the low two address
	// bits select bytes and are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HoldoffReset;
		end else if (cfg_wr && (paddr[CfgAddrW-1:2] == AddrHoldoff[CfgAddrW-1:2])) begin
			hold_ticks_q <= pwdata[TicksW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[CfgAddrW-1:2] == AddrHoldoff[CfgAddrW-1:2]) begin
			prdata = 32'(hold_ticks_q);
		end
	end

	// The controller decides the sequence of steps; the datapath owns all state.
	fta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fta_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.command          (command),
		.fault_index      (fault_index),
		.is_permanent     (is_permanent),
		.is_resettable    (is_resettable),
		.pin_fault_level  (pin_fault_level),
		.pin_faultn_level (pin_faultn_level),
		.hold_ticks       (hold_ticks_q),
		.done             (done),
		.status           (status),
		.assigned_index   (assigned_index),
		.fault_out        (fault_out),
		.faultn_out       (faultn_out),
		.clearing         (clearing)
	);

	// A result beat only appears once the controller has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted command always occupies the controller for the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted without going busy");

	// Exactly one result per command, so result beats never come back to back.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

	// A failed command never hands out a table index.
	a_fail_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != StOk)) |-> (assigned_index == '0))
		else $error("index assigned on a failed command");

endmodule

// ===== hw/rtl/fta_ctrl.sv =====
// Controller state machine that sequences each command through the datapath.
module fta_ctrl import fta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  fta_stat_t stat,
	output fta_cmd_t  cmd,
	output logic      busy
);

	fta_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.op)
					OP_REGISTER: begin
						cmd.do_register = 1'b1;
						state_d         = ST_DONE;
					end
					OP_TRIGGER, OP_CLEAR_ONE: begin
						state_d = stat.idx_valid ? ST_RMW_RD : ST_DONE;
					end
					OP_CLEAR_NP: begin
						cmd.walk_start = 1'b1;
						state_d        = ST_CLEAR;
					end
					OP_GCLEAR: begin
						cmd.walk_start = 1'b1;
						state_d        = ST_SCAN;
					end
					OP_TICK: begin
						cmd.do_tick = 1'b1;
						state_d     = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_RMW_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				cmd.wr_rmw     = 1'b1;
				cmd.walk_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_done) begin
					if (stat.op == OP_GCLEAR) begin
						if (stat.refuse) begin
							cmd.set_refused = 1'b1;
							state_d         = ST_DONE;
						end else begin
							cmd.walk_start = 1'b1;
							state_d        = ST_CLEAR;
						end
					end else begin
						state_d = ST_TABLE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.walk_step  = 1'b1;
				cmd.walk_clear = 1'b1;
				if (stat.walk_done) begin
					state_d = ST_TABLE;
				end
			end
			ST_TABLE: begin
				cmd.apply_table   = 1'b1;
				cmd.gclear_commit = (stat.op == OP_GCLEAR);
				state_d           = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/fta_dp.sv =====
// Datapath: fault table memory, table walk, pin sampling, latches and hold-off.
module fta_dp import fta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fta_cmd_t          cmd,
	output fta_stat_t         stat,
	input  logic [2:0]        command,
	input  logic [4:0]        fault_index,
	input  logic              is_permanent,
	input  logic              is_resettable,
	input  logic              pin_fault_level,
	input  logic              pin_faultn_level,
	input  logic [TicksW-1:0] hold_ticks,
	output logic              done,
	output logic [1:0]        status,
	output logic [4:0]        assigned_index,
	output logic              fault_out,
	output logic              faultn_out,
	output logic              clearing
);

	// Flag bits: 0 triggered, 1 permanent, 2 resettable.
	logic [2:0] flags_mem [MaxFaults];
	logic [2:0] rd_data_q;

	// Latched input item.
	fta_op_t    op_q;
	logic [4:0] idx_q;
	logic       perm_q;
	logic       rst_q;
	logic       pf_q;
	logic       pfn_q;

	logic [CntW-1:0]   count_q;
	logic [1:0]        pin_q;
	logic [1:0]        table_q;
	logic [1:0]        latch_q;
	logic              clear_q;
	logic [TicksW-1:0] holdoff_q;

	logic [CntW-1:0] walk_q;
	logic            pend_q;
	logic [IdxW-1:0] pend_addr_q;
	logic [1:0]      sig_q;
	logic            refuse_q;

	logic [1:0] st_q;
	logic [4:0] asg_q;

	logic            idx_valid;
	logic            walk_more;
	logic            rd_en;
	logic [IdxW-1:0] rd_addr;
	logic            wr_en;
	logic [IdxW-1:0] wr_addr;
	logic [2:0]      wr_data;
	logic            trig_post;
	logic [1:0]      new_pins;
	logic [1:0]      tbl_latch;
	logic [1:0]      pin_latch;

	assign idx_valid = ({1'b0, idx_q} < count_q);
	assign walk_more = (walk_q < count_q);

	assign stat.op        = op_q;
	assign stat.idx_valid = idx_valid;
	assign stat.walk_done = !walk_more && !pend_q;
	assign stat.refuse    = refuse_q | pin_q[1];

	// Memory read port.
	assign rd_en   = cmd.rd_idx | (cmd.walk_step & walk_more);
	assign rd_addr = cmd.rd_idx ? IdxW'(idx_q) : walk_q[IdxW-1:0];

	// An entry survives a clear walk triggered only if it is permanent.
	assign trig_post = rd_data_q[0] & (rd_data_q[1] | !cmd.walk_clear);

	// Memory write port: one writer at a time by construction of the sequence.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rd_data_q;
		if (cmd.do_register) begin
			wr_en   = (count_q < CntW'(MaxFaults));
			wr_addr = count_q[IdxW-1:0];
			wr_data = {rst_q, perm_q, 1'b0};
		end else if (cmd.wr_rmw) begin
			wr_en   = 1'b1;
			wr_addr = IdxW'(idx_q);
			wr_data = {rd_data_q[2:1], (op_q == OP_TRIGGER)};
		end else if (pend_q && cmd.walk_clear && !rd_data_q[1]) begin
			wr_en   = 1'b1;
			wr_data = {rd_data_q[2:1], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= flags_mem[rd_addr];
		end
	end

	// Rising edges of (pin | table) set the sticky latches.
	assign tbl_latch = latch_q | ((pin_q | sig_q) & ~(pin_q | table_q));
	assign new_pins  = {~pfn_q, ~pf_q};
	assign pin_latch = latch_q | ((new_pins | table_q) & ~(pin_q | table_q));

	// Latched item and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= fta_op_t'(command);
			idx_q  <= fault_index;
			perm_q <= is_permanent;
			rst_q  <= is_resettable;
			pf_q   <= pin_fault_level;
			pfn_q  <= pin_faultn_level;
			st_q   <= StOk;
			asg_q  <= '0;
		end else if (cmd.do_register) begin
			if (count_q < CntW'(MaxFaults)) begin
				asg_q <= 5'(count_q);
			end else begin
				st_q <= StFull;
			end
		end else if (cmd.set_refused) begin
			st_q <= StRefused;
		end
		if (cmd.emit) begin
			status         <= st_q;
			assigned_index <= asg_q;
			fault_out      <= latch_q[0];
			faultn_out     <= latch_q[1];
			clearing       <= clear_q;
		end
	end

	// Walk bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			sig_q       <= '0;
			refuse_q    <= 1'b0;
		end else if (cmd.walk_start) begin
			walk_q   <= '0;
			pend_q   <= 1'b0;
			sig_q    <= '0;
			refuse_q <= 1'b0;
		end else begin
			if (cmd.walk_step && walk_more) begin
				walk_q      <= walk_q + 1'b1;
				pend_q      <= 1'b1;
				pend_addr_q <= walk_q[IdxW-1:0];
			end else begin
				pend_q <= 1'b0;
			end
			if (pend_q) begin
				if (trig_post) begin
					sig_q <= sig_q | (rd_data_q[2] ? 2'b01 : 2'b10);
				end
				if (rd_data_q[0] && rd_data_q[1]) begin
					refuse_q <= 1'b1;
				end
			end
		end
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pin_q     <= '0;
			table_q   <= '0;
			latch_q   <= '0;
			clear_q   <= 1'b0;
			holdoff_q <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.do_register && (count_q < CntW'(MaxFaults))) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.apply_table) begin
				table_q <= sig_q;
				latch_q <= cmd.gclear_commit ? (tbl_latch & 2'b10) : tbl_latch;
				if (cmd.gclear_commit) begin
					clear_q   <= 1'b1;
					holdoff_q <= (hold_ticks == '0) ? TicksW'(1) : hold_ticks;
				end
			end
			if (cmd.do_tick) begin
				if (!clear_q) begin
					pin_q   <= new_pins;
					latch_q <= pin_latch;
				end else if (holdoff_q <= TicksW'(1)) begin
					holdoff_q <= '0;
					clear_q   <= 1'b0;
				end else begin
					holdoff_q <= holdoff_q - 1'b1;
				end
			end
		end
	end

endmodule
